// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);
// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error(msg);
`else
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg)
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr, msg)
`endif

`endif

// ===== src/afp_pkg.sv =====
// ----------------------------------------------------------------------------
// afp_pkg
// Frame codes, result codes and scaling constants of the FIFO frame parser.
// ----------------------------------------------------------------------------
package afp_pkg;

	typedef logic [2:0] kind_t;
	typedef logic [1:0] res_t;

	// frame kinds held while a frame is open
	localparam kind_t KIND_NONE = 3'd0;
	localparam kind_t KIND_DATA = 3'd1;
	localparam kind_t KIND_TIME = 3'd2;
	localparam kind_t KIND_CONF = 3'd3;
	localparam kind_t KIND_DROP = 3'd4;
	localparam kind_t KIND_SKIP = 3'd5;

	// result kinds
	localparam res_t RES_SAMPLE = 2'd0;
	localparam res_t RES_DROP   = 2'd1;
	localparam res_t RES_SKIP   = 2'd2;
	localparam res_t RES_END    = 2'd3;

	// header bytes
	localparam logic [7:0] HDR_MASK = 8'hFC;
	localparam logic [7:0] HDR_DATA = 8'h84;
	localparam logic [7:0] HDR_SKIP = 8'h40;
	localparam logic [7:0] HDR_TIME = 8'h44;
	localparam logic [7:0] HDR_CONF = 8'h48;
	localparam logic [7:0] HDR_DROP = 8'h50;

	// payload lengths in bytes
	localparam logic [2:0] LEN_DATA = 3'd6;
	localparam logic [2:0] LEN_TIME = 3'd3;
	localparam logic [2:0] LEN_ONE  = 3'd1;

	localparam logic [1:0] RANGE_RESET = 2'd1;

	// 3g * 9.80665 / 32768 in Q16 is 588399 * 2^range / 10000 per LSB;
	// 588399 = 58 * 10000 + 8399
	localparam int unsigned MUL_INT  = 58;
	localparam int unsigned MUL_FRAC = 8399;
	localparam int unsigned ROUND_ADD = 5000;
	// 10000 = 16 * 625; floor(y / 625) ~ (y * RECIP_625) >> RECIP_SHIFT
	localparam int unsigned DIV_ODD     = 625;
	localparam int unsigned RECIP_625   = 429496;
	localparam int unsigned RECIP_SHIFT = 28;

endpackage

// ===== src/accel_fifo_frame_parser.sv =====
// ----------------------------------------------------------------------------
// accel_fifo_frame_parser
// Parses an accelerometer FIFO burst byte by byte and emits scaled samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one FIFO byte per request with
// burst_start marking the first byte of a burst. Output channel
// (out_valid/out_ready): one result per data, drop or leading skip frame,
// and one end result for an end or unknown header; axes are signed Q16
// m/s^2, zero unless result_kind is a sample; skip_count is zero unless
// the result is a skip count.
// Throughput: one byte per cycle while the output is not stalled. A
// result passes a frame parsing register and four stages of constant
// multiply, reciprocal divide by 10000 and sign.
// cfg_we writes the range code (reset 6g); write it only while idle.
// Reset clears the parser to the start of a burst and empties the pipe.
// When out_ready is low with a result waiting, the whole pipe holds and
// in_ready drops; no request is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module accel_fifo_frame_parser
	import afp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         fifo_byte,
	input  logic               burst_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic signed [24:0] accel_x,
	output logic signed [24:0] accel_y,
	output logic signed [24:0] accel_z,
	output logic [7:0]         skip_count
);

	logic        adv;
	logic        accept;
	logic [1:0]  range_q;

	// parser state
	logic [2:0]  bytes_left_q;
	kind_t       frame_kind_q;
	logic [39:0] payload_q;
	logic        at_first_q;
	logic        stopped_q;

	logic [2:0]  bl_eff, bl_nx;
	kind_t       kind_eff, kind_nx;
	logic        first_eff, first_nx;
	logic        stop_eff, stop_nx;
	logic [39:0] pay_nx;
	logic [7:0]  hdr;
	logic        emit;
	res_t        emit_kind;

	// stage 1: parsed result
	logic        valid_s1;
	res_t        kind_s1;
	logic [7:0]  skip_s1;
	logic [15:0] raw_s1 [3];

	// stage 2: magnitude products
	logic        valid_s2;
	res_t        kind_s2;
	logic [7:0]  skip_s2;
	logic        neg_s2  [3];
	logic [20:0] base_s2 [3];
	logic [28:0] prod_s2 [3];

	// stage 3: reciprocal estimate
	logic        valid_s3;
	res_t        kind_s3;
	logic [7:0]  skip_s3;
	logic        neg_s3  [3];
	logic [23:0] base_s3 [3];
	logic [27:0] y_s3    [3];
	logic [18:0] q0_s3   [3];

	// stage 4: corrected quotient
	logic        valid_s4;
	res_t        kind_s4;
	logic [7:0]  skip_s4;
	logic        neg_s4  [3];
	logic [23:0] base_s4 [3];
	logic [18:0] q_s4    [3];

	// result register
	logic        out_valid_q;
	res_t        kind_q;
	logic [7:0]  skip_q;
	logic [24:0] acc_q [3];

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RESET;
		end else if (cfg_we) begin
			range_q <= cfg_wdata;
		end
	end

	// ---------------- frame parser ----------------
	always_comb begin
		bl_eff    = burst_start ? 3'd0 : bytes_left_q;
		kind_eff  = burst_start ? KIND_NONE : frame_kind_q;
		first_eff = burst_start || at_first_q;
		stop_eff  = !burst_start && stopped_q;
		hdr       = fifo_byte & HDR_MASK;
		bl_nx     = bl_eff;
		kind_nx   = kind_eff;
		first_nx  = first_eff;
		stop_nx   = stop_eff;
		pay_nx    = payload_q;
		emit      = 1'b0;
		emit_kind = RES_END;
		if (!stop_eff) begin
			if (bl_eff == 3'd0) begin
				first_nx = 1'b0;
				if (first_eff && hdr == HDR_SKIP) begin
					kind_nx = KIND_SKIP;
					bl_nx   = LEN_ONE;
				end else if (hdr == HDR_DATA) begin
					kind_nx = KIND_DATA;
					bl_nx   = LEN_DATA;
				end else if (hdr == HDR_TIME) begin
					kind_nx = KIND_TIME;
					bl_nx   = LEN_TIME;
				end else if (hdr == HDR_CONF) begin
					kind_nx = KIND_CONF;
					bl_nx   = LEN_ONE;
				end else if (hdr == HDR_DROP) begin
					kind_nx = KIND_DROP;
					bl_nx   = LEN_ONE;
				end else begin
					kind_nx   = KIND_NONE;
					stop_nx   = 1'b1;
					emit      = 1'b1;
					emit_kind = RES_END;
				end
			end else begin
				if (kind_eff == KIND_DATA) begin
					case (bl_eff)
						3'd6: pay_nx[7:0]   = fifo_byte;
						3'd5: pay_nx[15:8]  = fifo_byte;
						3'd4: pay_nx[23:16] = fifo_byte;
						3'd3: pay_nx[31:24] = fifo_byte;
						3'd2: pay_nx[39:32] = fifo_byte;
						default: ;
					endcase
				end
				bl_nx = bl_eff - 3'd1;
				if (bl_nx == 3'd0) begin
					kind_nx = KIND_NONE;
					case (kind_eff)
						KIND_DATA: begin
							emit      = 1'b1;
							emit_kind = RES_SAMPLE;
						end
						KIND_DROP: begin
							emit      = 1'b1;
							emit_kind = RES_DROP;
						end
						KIND_SKIP: begin
							emit      = 1'b1;
							emit_kind = RES_SKIP;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 3'd0;
			frame_kind_q <= KIND_NONE;
			at_first_q   <= 1'b1;
			stopped_q    <= 1'b0;
		end else if (accept) begin
			bytes_left_q <= bl_nx;
			frame_kind_q <= kind_nx;
			at_first_q   <= first_nx;
			stopped_q    <= stop_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			payload_q <= pay_nx;
		end
	end

	// ---------------- pipeline valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept && emit;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= emit_kind;
			skip_s1   <= fifo_byte;
			raw_s1[0] <= payload_q[15:0];
			raw_s1[1] <= payload_q[31:16];
			raw_s1[2] <= {fifo_byte, payload_q[39:32]};
		end
	end

	always_ff @(posedge clk) begin
		logic [15:0] mag;
		if (adv) begin
			kind_s2 <= kind_s1;
			skip_s2 <= skip_s1;
			for (int i = 0; i < 3; i++) begin
				mag         = raw_s1[i][15] ? 16'(16'd0 - raw_s1[i]) : raw_s1[i];
				neg_s2[i]   <= raw_s1[i][15];
				base_s2[i]  <= 21'(21'(mag) * 21'(MUL_INT));
				prod_s2[i]  <= 29'(29'(mag) * 29'(MUL_FRAC));
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] n;
		logic [46:0] t;
		if (adv) begin
			kind_s3 <= kind_s2;
			skip_s3 <= skip_s2;
			for (int i = 0; i < 3; i++) begin
				n          = (32'(prod_s2[i]) << range_q) + 32'(ROUND_ADD);
				t          = 47'(n[31:4]) * 47'(RECIP_625);
				neg_s3[i]  <= neg_s2[i];
				base_s3[i] <= 24'(base_s2[i]) << range_q;
				y_s3[i]    <= n[31:4];
				q0_s3[i]   <= t[46:RECIP_SHIFT];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [28:0] qm;
		logic [28:0] rem;
		if (adv) begin
			kind_s4 <= kind_s3;
			skip_s4 <= skip_s3;
			for (int i = 0; i < 3; i++) begin
				qm         = 29'(29'(q0_s3[i]) * 29'(DIV_ODD));
				rem        = {1'b0, y_s3[i]} - qm;
				neg_s4[i]  <= neg_s3[i];
				base_s4[i] <= base_s3[i];
				q_s4[i]    <= (rem >= 29'(DIV_ODD)) ? q0_s3[i] + 19'd1 : q0_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [24:0] tot;
		if (adv) begin
			kind_q <= kind_s4;
			skip_q <= (kind_s4 == RES_SKIP) ? skip_s4 : 8'd0;
			for (int i = 0; i < 3; i++) begin
				tot = 25'(base_s4[i]) + 25'(q_s4[i]);
				if (kind_s4 != RES_SAMPLE) begin
					acc_q[i] <= 25'd0;
				end else begin
					acc_q[i] <= neg_s4[i] ? 25'(25'd0 - tot) : tot;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign skip_count  = skip_q;
	assign accel_x     = signed'(acc_q[0]);
	assign accel_y     = signed'(acc_q[1]);
	assign accel_z     = signed'(acc_q[2]);

	// ---------------- assertions ----------------
	`ASSERT_CLK(a_stopped_silent, clk, arst_n,
		accept && stopped_q && !burst_start |=> !valid_s1,
		"result produced after end of burst")
	`ASSERT_CLK(a_kind_matches_count, clk, arst_n,
		(frame_kind_q == KIND_NONE) == (bytes_left_q == 3'd0),
		"frame kind and byte count disagree")
	`ASSERT_NEVER(a_count_range, clk, arst_n,
		bytes_left_q > LEN_DATA,
		"byte count out of range")
	`ASSERT_CLK(a_axes_zero, clk, arst_n,
		out_valid && result_kind != RES_SAMPLE |->
			accel_x == 25'sd0 && accel_y == 25'sd0 && accel_z == 25'sd0,
		"nonzero axes in non-sample result")
	`ASSERT_CLK(a_skip_zero, clk, arst_n,
		out_valid && result_kind != RES_SKIP |-> skip_count == 8'd0,
		"nonzero skip count in non-skip result")

endmodule

// ===== bench/accel_fifo_frame_parser_test.sv =====
// ----------------------------------------------------------------------------
// accel_fifo_frame_parser_test
// Self-checking bench for the FIFO frame parser. A queue of FIFO bytes is
// offered with random gaps. Each accepted byte runs through an in-bench
// parser that predicts the scaled sample, drop, skip or end result. Results
// are compared field by field in order. The range code is stepped through
// several values, and one long output stall backs up the pipe.
// ----------------------------------------------------------------------------
module accel_fifo_frame_parser_test
	import afp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] HDR_END = 8'h80;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_BYTES = 70;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} fifo_req_t;

	typedef struct packed {
		res_t               kind;
		logic signed [24:0] x;
		logic signed [24:0] y;
		logic signed [24:0] z;
		logic [7:0]         skip;
	} result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         fifo_byte;
	logic               burst_start;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         result_kind;
	logic signed [24:0] accel_x;
	logic signed [24:0] accel_y;
	logic signed [24:0] accel_z;
	logic [7:0]         skip_count;

	accel_fifo_frame_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.fifo_byte   (fifo_byte),
		.burst_start (burst_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.skip_count  (skip_count)
	);

	fifo_req_t pending[$];
	result_t   expected[$];

	// in-bench parser state
	logic [1:0]  range_sel = RANGE_RESET;
	logic [2:0]  p_left = '0;
	kind_t       p_kind = KIND_NONE;
	logic [47:0] p_pay = '0;
	bit          p_first = 1'b1;
	bit          p_halt = 1'b0;

	int errors = 0;
	int quiet_cycles = 0;
	int phase_bytes = 0;
	int hold_left = 0;
	bit in_taken = 1'b0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit lead = 1'b0;

	always #4 clk = ~clk;

	function automatic logic signed [24:0] to_mps2(input logic [15:0] raw);
		longint unsigned mag;
		longint unsigned prod;
		longint unsigned q;
		logic [24:0] v;
		mag = raw[15] ? (64'd65536 - {48'd0, raw}) : {48'd0, raw};
		prod = mag * (64'd3 << range_sel) * 64'd196133;
		q = (prod + 64'd5000) / 64'd10000;
		v = q[24:0];
		return raw[15] ? -v : v;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, input logic st,
			output result_t r);
		logic [7:0] hdr;
		bit first_now;
		r = '0;
		if (st) begin
			p_left = '0;
			p_kind = KIND_NONE;
			p_pay = '0;
			p_first = 1'b1;
			p_halt = 1'b0;
		end
		if (p_halt)
			return 1'b0;
		if (p_left == 0) begin
			hdr = b & HDR_MASK;
			first_now = p_first;
			p_first = 1'b0;
			p_pay = '0;
			if (first_now && hdr == HDR_SKIP) begin
				p_kind = KIND_SKIP;
				p_left = LEN_ONE;
			end else if (hdr == HDR_DATA) begin
				p_kind = KIND_DATA;
				p_left = LEN_DATA;
			end else if (hdr == HDR_TIME) begin
				p_kind = KIND_TIME;
				p_left = LEN_TIME;
			end else if (hdr == HDR_CONF) begin
				p_kind = KIND_CONF;
				p_left = LEN_ONE;
			end else if (hdr == HDR_DROP) begin
				p_kind = KIND_DROP;
				p_left = LEN_ONE;
			end else begin
				p_kind = KIND_NONE;
				p_halt = 1'b1;
				r.kind = RES_END;
				return 1'b1;
			end
			return 1'b0;
		end
		if (p_kind == KIND_DATA)
			p_pay[(6 - p_left) * 8 +: 8] = b;
		p_left = p_left - 3'd1;
		if (p_left != 0)
			return 1'b0;
		case (p_kind)
			KIND_DATA: begin
				r.kind = RES_SAMPLE;
				r.x = to_mps2(p_pay[15:0]);
				r.y = to_mps2(p_pay[31:16]);
				r.z = to_mps2(p_pay[47:32]);
				p_kind = KIND_NONE;
				return 1'b1;
			end
			KIND_DROP: begin
				r.kind = RES_DROP;
				p_kind = KIND_NONE;
				return 1'b1;
			end
			KIND_SKIP: begin
				r.kind = RES_SKIP;
				r.skip = b;
				p_kind = KIND_NONE;
				return 1'b1;
			end
			default: begin
				p_kind = KIND_NONE;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report(input string msg);
		$display("%0t ns mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// request acceptance, prediction and result checking
	always @(posedge clk) begin : monitor
		result_t r;
		result_t want;
		bit moved;
		in_taken = 1'b0;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				moved = 1'b1;
				if (parse_byte(fifo_byte, burst_start, r))
					expected.push_back(r);
				void'(pending.pop_front());
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (expected.size() == 0) begin
					report($sformatf("result kind %0d with nothing pending", result_kind));
				end else begin
					want = expected.pop_front();
					if (result_kind !== want.kind)
						report($sformatf("result_kind %0d, want %0d", result_kind, want.kind));
					if (accel_x !== want.x)
						report($sformatf("accel_x %0d, want %0d", accel_x, want.x));
					if (accel_y !== want.y)
						report($sformatf("accel_y %0d, want %0d", accel_y, want.y));
					if (accel_z !== want.z)
						report($sformatf("accel_z %0d, want %0d", accel_z, want.z));
					if (skip_count !== want.skip)
						report($sformatf("skip_count %0d, want %0d", skip_count, want.skip));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	always @(negedge clk) begin : driver
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
				in_valid <= 1'b1;
				fifo_byte <= pending[0].data;
				burst_start <= pending[0].start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(99) >= 32;
		end
	end

	always @(negedge clk) begin : watchdog
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("accel_fifo_frame_parser_test: errors");
			$finish;
		end
	end

	task automatic put(input logic [7:0] b);
		fifo_req_t req;
		req.data = b;
		req.start = lead;
		pending.push_back(req);
		lead = 1'b0;
		phase_bytes++;
	endtask

	function automatic logic [7:0] low2();
		return 8'($urandom_range(3));
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [7:0] unknown_hdr();
		logic [7:0] h;
		h = any_byte();
		while ((h & HDR_MASK) == HDR_DATA || (h & HDR_MASK) == HDR_TIME ||
				(h & HDR_MASK) == HDR_CONF || (h & HDR_MASK) == HDR_DROP)
			h = any_byte();
		return h;
	endfunction

	task automatic put_data(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		put(HDR_DATA | low2());
		put(x[7:0]);
		put(x[15:8]);
		put(y[7:0]);
		put(y[15:8]);
		put(z[7:0]);
		put(z[15:8]);
	endtask

	task automatic random_burst();
		int frames;
		int pick;
		lead = 1'b1;
		if ($urandom_range(1)) begin
			put(HDR_SKIP | low2());
			put(any_byte());
		end
		frames = $urandom_range(1, 8);
		for (int i = 0; i < frames; i++) begin
			pick = $urandom_range(9);
			if (pick < 5) begin
				put_data(pick_axis(), pick_axis(), pick_axis());
			end else if (pick == 5) begin
				put(HDR_TIME | low2());
				repeat (3) put(any_byte());
			end else if (pick == 6) begin
				put(HDR_CONF | low2());
				put(any_byte());
			end else if (pick == 7) begin
				put(HDR_DROP | low2());
				put(any_byte());
			end else if (pick == 8) begin
				// frame cut short by the next burst
				put(HDR_DATA | low2());
				repeat ($urandom_range(5)) put(any_byte());
				return;
			end else begin
				put(any_byte());
			end
		end
		pick = $urandom_range(9);
		if (pick < 7)
			put(HDR_END | low2());
		else if (pick < 9)
			put(unknown_hdr());
		repeat ($urandom_range(3)) put(any_byte());
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || expected.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_range(input logic [1:0] code);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(negedge clk);
		cfg_we <= 1'b0;
		range_sel = code;
	endtask

	task automatic random_phase(input logic [1:0] code);
		write_range(code);
		phase_bytes = 0;
		while (phase_bytes < PHASE_BYTES)
			random_burst();
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		fifo_byte = '0;
		burst_start = 1'b0;
		out_ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no burst start after reset; skip frame first
		lead = 1'b0;
		put(HDR_SKIP | 8'd3);
		put(8'hFF);
		put_data(16'h8000, 16'h7FFF, 16'h0000);
		put(HDR_TIME);
		put(8'h00);
		put(8'hFF);
		put(8'h5A);
		put(HDR_CONF | 8'd3);
		put(8'hFF);
		put(HDR_DROP | 8'd1);
		put(8'h00);
		// late skip header ends the burst, then bytes are ignored
		put(HDR_SKIP);
		put(HDR_DATA);
		lead = 1'b1;
		put(HDR_SKIP);
		put(8'h00);
		// burst start in the middle of a data frame
		put(HDR_DATA | 8'd2);
		put(8'h12);
		put(8'h34);
		lead = 1'b1;
		put(HDR_END);
		wait_idle();

		calm = 1'b1;
		random_phase(2'd3);
		calm = 1'b0;
		hold_req = 1'b1;
		random_phase(2'd0);
		random_phase(2'd2);
		random_phase(2'($urandom_range(3)));
		random_phase(2'($urandom_range(3)));

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("accel_fifo_frame_parser_test: clean");
		else
			$display("accel_fifo_frame_parser_test: errors");
		$finish;
	end

endmodule
